[hdl/rc_pkg.sv]
// ----------------------------------------------------------------------------
// Repetitive controller package
// Shared field widths, payload structs, register codes and the control and
// status structs of the serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package rc_pkg;

  localparam int PHASE_W   = 16;
  localparam int SAMPLE_W  = 16;
  localparam int ERR_W     = SAMPLE_W + 1;
  localparam int VAL_W     = 24;
  localparam int COEF_W    = 16;
  localparam int OPND_W    = VAL_W + 1;
  localparam int ACC_W     = 44;
  localparam int FRAC_SH   = 14;
  localparam int RND_W     = ACC_W - FRAC_SH;
  localparam int LEN_CFG_W = 9;
  localparam int K_W       = 10;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Register values after reset.
  localparam logic [LEN_CFG_W-1:0]     BUFLEN_RST  = 9'd256;
  localparam logic signed [K_W-1:0]    DELAY_RST   = 10'sd0;
  localparam logic signed [COEF_W-1:0] GAIN_RST    = 16'sd0;
  localparam logic signed [COEF_W-1:0] WCENTER_RST = 16'sd16384;
  localparam logic signed [COEF_W-1:0] WNEAR_RST   = 16'sd0;
  localparam logic signed [COEF_W-1:0] WFAR_RST    = 16'sd0;
  localparam logic signed [VAL_W-1:0]  AMAX_RST    = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0]  AMIN_RST    = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_LENGTH,
    REG_DELAY_COMP,
    REG_GAIN,
    REG_WEIGHT_CENTER,
    REG_WEIGHT_NEAR,
    REG_WEIGHT_FAR,
    REG_ACCUM_MAX,
    REG_ACCUM_MIN
  } cfg_reg_t;

  typedef struct packed {
    logic        [PHASE_W-1:0]  phase;
    logic signed [SAMPLE_W-1:0] reference;
    logic signed [SAMPLE_W-1:0] feedback;
  } sample_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] drive;
    logic                    updated;
  } result_t;

  typedef struct packed {
    logic                     load;
    logic                     clear;
    logic signed [COEF_W-1:0] coef;
    logic signed [OPND_W-1:0] mcand;
  } mac_ctrl_t;

  typedef struct packed {
    logic                    busy;
    logic signed [ACC_W-1:0] acc;
  } mac_stat_t;

endpackage

[hdl/repetitive_controller.sv]
// A sample that stays in the same slot gives its result straight from the compare
// state; a sample that moves to a new slot first takes four serial multiplications
// in the shared multiply-accumulate, then the round, write, read and fetch states.
// Throughput: one sample at a time; the next is taken the cycle after the result
// enters the output register. After reset the history is cleared slot by slot,
// during which no sample is taken; configuration writes are always taken.
// ----------------------------------------------------------------------------
// Repetitive controller
// Phase-indexed error history with a symmetric FIR update around the active
// slot and a delay-compensated output slot.
// ----------------------------------------------------------------------------
module repetitive_controller #(
  parameter int MAX_DEPTH = 256,
  parameter int MIN_DEPTH = 20,
  parameter int DRIVE_MAX = 8388607,
  parameter int DRIVE_MIN = -8388608
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  rc_pkg::sample_t                 sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output rc_pkg::result_t                 result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rc_pkg::CFG_W-1:0]        cfg_data
);
  import rc_pkg::*;

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int CW = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
  localparam int IW = ((LW > K_W) ? LW : K_W) + 2;
  localparam int DW = AW + 3;
  localparam int PW = PHASE_W + LW;
  localparam logic signed [VAL_W-1:0] DMAX = VAL_W'(DRIVE_MAX);
  localparam logic signed [VAL_W-1:0] DMIN = VAL_W'(DRIVE_MIN);
  localparam logic [2:0] RD_DONE = 3'd5;
  localparam logic [1:0] PROD_LAST = 2'd3;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (FRAC_SH - 1));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SLOT, S_CMP, S_PROD, S_ROUND, S_WRITE, S_READ, S_FETCH, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [LEN_CFG_W-1:0]     buffer_length;
  logic signed [K_W-1:0]    delay_comp;
  logic signed [COEF_W-1:0] gain;
  logic signed [COEF_W-1:0] weight_center;
  logic signed [COEF_W-1:0] weight_near;
  logic signed [COEF_W-1:0] weight_far;
  logic signed [VAL_W-1:0]  accum_max;
  logic signed [VAL_W-1:0]  accum_min;

  // Per-sample working registers.
  logic [PHASE_W-1:0]      phase_r;
  logic signed [ERR_W-1:0] err_r;
  logic [AW-1:0]           slot;
  logic [AW-1:0]           last_slot;
  logic                    dir_r;
  logic signed [VAL_W-1:0] held_drive;
  logic signed [VAL_W-1:0] res_drive;
  logic                    res_upd;
  logic signed [RND_W-1:0] rnd_r;
  logic [AW-1:0]           clr_cnt;
  logic [1:0]              prod_sel;
  logic [2:0]              rd_cnt;
  logic [2:0]              rd_tag;
  logic                    rd_pend;
  logic signed [VAL_W-1:0] hreg [5];

  // Derived values.
  logic [CW-1:0]           blen_w;
  logic [CW-1:0]           len_w;
  logic [LW-1:0]           len;
  logic [PW-1:0]           phase_prod;
  logic [AW-1:0]           slot_next;
  logic signed [IW-1:0]    len_i;
  logic signed [IW-1:0]    dc_i;
  logic signed [IW-1:0]    k_clamp;
  logic signed [IW-1:0]    k_dir;
  logic signed [IW-1:0]    slot_i;
  logic [AW-1:0]           out_idx;
  logic signed [IW-1:0]    rd_off;
  logic [AW-1:0]           rd_addr;
  logic signed [DW-1:0]    delta;
  logic signed [DW-1:0]    delta_c;
  logic signed [DW-1:0]    len_d;
  logic signed [DW-1:0]    half_d;
  logic                    dir_next;
  logic signed [ACC_W-1:0] biased;
  logic signed [RND_W-1:0] amax_w;
  logic signed [RND_W-1:0] amin_w;
  logic signed [RND_W-1:0] sat_w;
  logic [1:0]              load_sel;

  // Memory and multiply-accumulate connections.
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata;
  mac_ctrl_t               mac_ctrl;
  mac_stat_t               mac_stat;

  function automatic logic [AW-1:0] wrap_idx(input logic signed [IW-1:0] x,
                                             input logic signed [IW-1:0] l);
    logic signed [IW-1:0] y;
    if (x >= l) begin
      y = x - l;
    end else if (x[IW-1]) begin
      y = x + l;
    end else begin
      y = x;
    end
    return y[AW-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_drive(input logic signed [VAL_W-1:0] x);
    logic signed [VAL_W-1:0] y;
    y = (x > DMAX) ? DMAX : x;
    if (y < DMIN) begin
      y = DMIN;
    end
    return y;
  endfunction

  // Effective length and delay offset.
  assign blen_w = CW'(buffer_length);
  always_comb begin
    if (blen_w > CW'(MAX_DEPTH)) begin
      len_w = CW'(MAX_DEPTH);
    end else if (blen_w < CW'(MIN_DEPTH)) begin
      len_w = CW'(MIN_DEPTH);
    end else begin
      len_w = blen_w;
    end
  end
  assign len = len_w[LW-1:0];

  assign phase_prod = PW'(phase_r) * PW'(len);
  assign slot_next  = phase_prod[PHASE_W +: AW];

  assign len_i  = IW'($signed({1'b0, len}));
  assign dc_i   = IW'(delay_comp);
  assign slot_i = IW'($signed({1'b0, slot}));

  always_comb begin
    if (dc_i > len_i) begin
      k_clamp = len_i;
    end else if (dc_i < -len_i) begin
      k_clamp = -len_i;
    end else begin
      k_clamp = dc_i;
    end
  end
  assign k_dir   = dir_r ? k_clamp : -k_clamp;
  assign out_idx = wrap_idx(slot_i + k_dir, len_i);

  // Neighbor fetch order: the slot itself, then +1, -1, +2, -2.
  always_comb begin
    case (rd_cnt)
      3'd1:    rd_off = IW'(1);
      3'd2:    rd_off = -IW'(1);
      3'd3:    rd_off = IW'(2);
      3'd4:    rd_off = -IW'(2);
      default: rd_off = '0;
    endcase
  end
  assign rd_addr = wrap_idx(slot_i + rd_off, len_i);

  // Circular step direction; a stale last slot above the length only shows here.
  assign delta  = DW'($signed({1'b0, slot})) - DW'($signed({1'b0, last_slot}));
  assign len_d  = DW'($signed({1'b0, len}));
  assign half_d = len_d >>> 1;
  always_comb begin
    if (slot < last_slot && delta < -half_d) begin
      delta_c = delta + len_d;
    end else if (slot > last_slot && delta > half_d) begin
      delta_c = delta - len_d;
    end else begin
      delta_c = delta;
    end
  end
  assign dir_next = !delta_c[DW-1] && (delta_c != '0);

  // Round the Q30.14 accumulator half up to an integer, then the upper limit and the lower limit last.
  assign biased = mac_stat.acc + ROUND_BIAS;
  assign amax_w = RND_W'(accum_max);
  assign amin_w = RND_W'(accum_min);
  always_comb begin
    sat_w = (rnd_r > amax_w) ? amax_w : rnd_r;
    if (sat_w < amin_w) begin
      sat_w = amin_w;
    end
  end

  always_comb begin
    mac_ctrl.load  = 1'b0;
    mac_ctrl.clear = 1'b0;
    load_sel       = prod_sel + 1'b1;
    if (state == S_CMP && slot != last_slot) begin
      mac_ctrl.load  = 1'b1;
      mac_ctrl.clear = 1'b1;
      load_sel       = '0;
    end else if (state == S_PROD && !mac_stat.busy && prod_sel != PROD_LAST) begin
      mac_ctrl.load = 1'b1;
    end
    case (load_sel)
      2'd0: begin
        mac_ctrl.coef  = gain;
        mac_ctrl.mcand = OPND_W'(err_r);
      end
      2'd1: begin
        mac_ctrl.coef  = weight_center;
        mac_ctrl.mcand = OPND_W'(hreg[0]);
      end
      2'd2: begin
        mac_ctrl.coef  = weight_near;
        mac_ctrl.mcand = OPND_W'(hreg[1]) + OPND_W'(hreg[2]);
      end
      default: begin
        mac_ctrl.coef  = weight_far;
        mac_ctrl.mcand = OPND_W'(hreg[3]) + OPND_W'(hreg[4]);
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = sat_w[VAL_W-1:0];
    mem_raddr = out_idx;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_WRITE: mem_we = 1'b1;
      S_PROD:  mem_raddr = rd_addr;
      default: ;
    endcase
  end

  rc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .stat (mac_stat)
  );

  rc_hist #(
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cfg_ready    = 1'b1;
  assign sample_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= BUFLEN_RST;
      delay_comp    <= DELAY_RST;
      gain          <= GAIN_RST;
      weight_center <= WCENTER_RST;
      weight_near   <= WNEAR_RST;
      weight_far    <= WFAR_RST;
      accum_max     <= AMAX_RST;
      accum_min     <= AMIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BUFFER_LENGTH: buffer_length <= cfg_data[LEN_CFG_W-1:0];
        REG_DELAY_COMP:    delay_comp    <= cfg_data[K_W-1:0];
        REG_GAIN:          gain          <= cfg_data[COEF_W-1:0];
        REG_WEIGHT_CENTER: weight_center <= cfg_data[COEF_W-1:0];
        REG_WEIGHT_NEAR:   weight_near   <= cfg_data[COEF_W-1:0];
        REG_WEIGHT_FAR:    weight_far    <= cfg_data[COEF_W-1:0];
        REG_ACCUM_MAX:     accum_max     <= cfg_data[VAL_W-1:0];
        REG_ACCUM_MIN:     accum_min     <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Neighbor values land in the cycle after their address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_PROD) && (rd_cnt != RD_DONE);
    end
    rd_tag <= rd_cnt;
    if (rd_pend) begin
      hreg[rd_tag] <= mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      last_slot    <= '0;
      held_drive   <= '0;
      result_valid <= 1'b0;
      prod_sel     <= '0;
      rd_cnt       <= RD_DONE;
    end else begin
      // The done state reloads the output register itself.
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (sample_valid) begin
            phase_r <= sample.phase;
            err_r   <= ERR_W'(sample.reference) - ERR_W'(sample.feedback);
            state   <= S_SLOT;
          end
        end
        S_SLOT: begin
          slot  <= slot_next;
          state <= S_CMP;
        end
        S_CMP: begin
          if (slot == last_slot) begin
            res_drive <= clamp_drive(held_drive);
            res_upd   <= 1'b0;
            state     <= S_DONE;
          end else begin
            dir_r    <= dir_next;
            prod_sel <= '0;
            rd_cnt   <= '0;
            state    <= S_PROD;
          end
        end
        S_PROD: begin
          if (rd_cnt != RD_DONE) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (!mac_stat.busy) begin
            if (prod_sel == PROD_LAST) begin
              state <= S_ROUND;
            end else begin
              prod_sel <= prod_sel + 1'b1;
            end
          end
        end
        S_ROUND: begin
          rnd_r <= biased[ACC_W-1:FRAC_SH];
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          res_drive <= clamp_drive(mem_rdata);
          res_upd   <= 1'b1;
          last_slot <= slot;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid   <= 1'b1;
            result.drive   <= res_drive;
            result.updated <= res_upd;
            held_drive     <= res_drive;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/rc_mac.sv]
// ----------------------------------------------------------------------------
// Serial multiply-accumulate unit
// Consumes the coefficient one bit per cycle, least significant first, and
// adds the shifted multiplicand into a wide accumulator (subtracts it for the sign bit).
// ----------------------------------------------------------------------------
module rc_mac (
  input  logic              clk,
  input  logic              rst,
  input  rc_pkg::mac_ctrl_t ctrl,
  output rc_pkg::mac_stat_t stat
);
  import rc_pkg::*;

  localparam int CNT_W = $clog2(COEF_W);

  logic [COEF_W-1:0]       coef_sr;
  logic signed [ACC_W-1:0] mcand_sr;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] addend;
  logic [CNT_W-1:0]        bit_cnt;
  logic                    busy;
  logic                    last_bit;

  assign addend   = coef_sr[0] ? mcand_sr : '0;
  assign last_bit = (bit_cnt == CNT_W'(COEF_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (ctrl.load) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 1'b1;
      if (last_bit) begin
        busy <= 1'b0;
      end
    end
  end

  // The sign bit of the coefficient carries negative weight, so it subtracts.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      coef_sr  <= ctrl.coef;
      mcand_sr <= ACC_W'(ctrl.mcand);
      if (ctrl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      coef_sr  <= coef_sr >> 1;
      mcand_sr <= mcand_sr <<< 1;
      acc      <= last_bit ? acc - addend : acc + addend;
    end
  end

  assign stat.busy = busy;
  assign stat.acc  = acc;

endmodule

[hdl/rc_hist.sv]
// ----------------------------------------------------------------------------
// History store
// Single-port-write, single-port-read memory of error history slots with a
// registered read.
// ----------------------------------------------------------------------------
module rc_hist #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic signed [rc_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]                  raddr,
  output logic signed [rc_pkg::VAL_W-1:0] rdata
);
  import rc_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/rc_checker.sv]
// ----------------------------------------------------------------------------
// Repetitive controller checker
// Port-level properties of the repetitive controller, attached by bind.
// ----------------------------------------------------------------------------
module rc_checker (
  input logic            clk,
  input logic            rst,
  input logic            sample_valid,
  input logic            sample_ready,
  input logic            result_valid,
  input logic            result_ready,
  input rc_pkg::result_t result
);
  import rc_pkg::*;

  logic signed [VAL_W-1:0] last_drive;
  logic                    seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (result_valid && result_ready) begin
      seen       <= 1'b1;
      last_drive <= result.drive;
    end
  end

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // A result without a history update repeats the previous drive.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && seen && !result.updated |-> result.drive == last_drive)
    else $error("held drive differs from previous result");

  // Only one sample is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while another is in work");

  // The history clear after reset keeps the input closed.
  assert property (@(posedge clk) rst |=> !sample_ready)
    else $error("sample ready during history clear");

endmodule

bind repetitive_controller rc_checker u_rc_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Repetitive controller testbench
// Drives phase-tagged samples through the valid/ready sample channel, keeps
// its own bit-exact copy of the history update and the output selection,
// and compares every result transfer against the oldest predicted result.
// Register settings are changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import rc_pkg::*;

  localparam int MAX_LEN     = 256;
  localparam int MIN_LEN     = 20;
  localparam int DRIVE_MAX   = 8388607;
  localparam int DRIVE_MIN   = -8388608;
  localparam int NUM_REGS    = 8;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 150;

  typedef enum {SWEEP, SCATTER, DWELL, HALF_TURN} walk_t;
  typedef enum {ALWAYS_READY, COIN_FLIP, SPARSE, MOSTLY_READY} stall_t;

  logic            clk;
  logic            rst;
  logic            sample_valid;
  logic            sample_ready;
  sample_t         sample;
  logic            result_valid;
  logic            result_ready;
  result_t         result;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor state: register copies, history and held output.
  logic [LEN_CFG_W-1:0]     cfg_length;
  logic signed [K_W-1:0]    cfg_delay;
  logic signed [COEF_W-1:0] cfg_gain;
  logic signed [COEF_W-1:0] cfg_w_center;
  logic signed [COEF_W-1:0] cfg_w_near;
  logic signed [COEF_W-1:0] cfg_w_far;
  logic signed [VAL_W-1:0]  cfg_acc_max;
  logic signed [VAL_W-1:0]  cfg_acc_min;
  logic signed [VAL_W-1:0]  error_history [0:MAX_LEN-1];
  int                       prev_slot;
  logic signed [VAL_W-1:0]  held_out;

  logic [CFG_W-1:0] cfg_plan [0:NUM_REGS-1];
  result_t          awaited_results[$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               burst_left  = 0;

  repetitive_controller dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [CFG_W-1:0] as_cfg(input int v);
    return v[CFG_W-1:0];
  endfunction

  function automatic int effective_length(input logic [LEN_CFG_W-1:0] v);
    if (v < MIN_LEN) return MIN_LEN;
    if (v > MAX_LEN) return MAX_LEN;
    return int'(v);
  endfunction

  // One correction is enough for every index the update can form.
  function automatic int fold_slot(input int x, input int len);
    if (x > len - 1) x -= len;
    else if (x < 0) x += len;
    if (x < 0 || x >= len) x = 0;
    return x;
  endfunction

  function automatic longint slot_value(input int x, input int len);
    longint v;
    v = error_history[fold_slot(x, len)];
    return v;
  endfunction

  function automatic result_t predict_drive(input sample_t s);
    int      len, k, ph, slot, delta, dir;
    longint  err, total, acc, drv;
    result_t r;
    len = effective_length(cfg_length);
    k = cfg_delay;
    if (k > len) k = len;
    if (k < -len) k = -len;
    ph = s.phase;
    slot = (ph * len) >> 16;
    drv = held_out;
    r.updated = 1'b0;
    if (slot != prev_slot) begin
      // A step of more than half a period is taken the short way around.
      delta = slot - prev_slot;
      if (slot < prev_slot && delta < -(len >> 1)) delta += len;
      else if (slot > prev_slot && delta > (len >> 1)) delta -= len;
      dir = (delta > 0) ? 1 : -1;
      err = longint'($signed(s.reference)) - longint'($signed(s.feedback));
      total = cfg_gain * err
            + cfg_w_center * slot_value(slot, len)
            + cfg_w_near * (slot_value(slot + dir, len) + slot_value(slot - dir, len))
            + cfg_w_far * (slot_value(slot + 2 * dir, len)
                           + slot_value(slot - 2 * dir, len));
      acc = (total + 8192) >>> FRAC_SH;
      if (acc > cfg_acc_max) acc = cfg_acc_max;
      if (acc < cfg_acc_min) acc = cfg_acc_min;
      error_history[slot] = acc[VAL_W-1:0];
      drv = slot_value(slot + k * dir, len);
      prev_slot = slot;
      r.updated = 1'b1;
    end
    if (drv > DRIVE_MAX) drv = DRIVE_MAX;
    if (drv < DRIVE_MIN) drv = DRIVE_MIN;
    held_out = drv[VAL_W-1:0];
    r.drive = drv[VAL_W-1:0];
    return r;
  endfunction

  task automatic send_sample(input int ph, input int refv, input int fdbv);
    sample_t s;
    int      gap;
    s.phase = ph[PHASE_W-1:0];
    s.reference = refv[SAMPLE_W-1:0];
    s.feedback = fdbv[SAMPLE_W-1:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7: gap = $urandom_range(1, 8);
        default: gap = $urandom_range(9, 120);
      endcase
      if (gap > 0) begin
        if (sample_valid) sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    awaited_results.push_back(predict_drive(s));
  endtask

  // Always waits for a clock edge before checking, so the lowered valid has settled
  // before anything else is driven.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic program_regs();
    int i;
    for (i = 0; i < NUM_REGS; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= cfg_plan[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (cfg_reg_t'(i))
        REG_BUFFER_LENGTH: cfg_length   = cfg_plan[i][LEN_CFG_W-1:0];
        REG_DELAY_COMP:    cfg_delay    = cfg_plan[i][K_W-1:0];
        REG_GAIN:          cfg_gain     = cfg_plan[i][COEF_W-1:0];
        REG_WEIGHT_CENTER: cfg_w_center = cfg_plan[i][COEF_W-1:0];
        REG_WEIGHT_NEAR:   cfg_w_near   = cfg_plan[i][COEF_W-1:0];
        REG_WEIGHT_FAR:    cfg_w_far    = cfg_plan[i][COEF_W-1:0];
        REG_ACCUM_MAX:     cfg_acc_max  = cfg_plan[i][VAL_W-1:0];
        REG_ACCUM_MIN:     cfg_acc_min  = cfg_plan[i][VAL_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Reset values: zero gain, so the history stays at zero.
  task automatic test_reset_state();
    send_sample(0, 32767, -32768);
    send_sample(65535, -32768, 32767);
    send_sample(256, 0, 0);
  endtask

  task automatic test_field_extremes();
    wait_idle();
    cfg_plan[REG_BUFFER_LENGTH] = as_cfg(20);
    cfg_plan[REG_DELAY_COMP]    = as_cfg(1);
    cfg_plan[REG_GAIN]          = as_cfg(-32768);
    cfg_plan[REG_WEIGHT_CENTER] = as_cfg(32767);
    cfg_plan[REG_WEIGHT_NEAR]   = as_cfg(-32768);
    cfg_plan[REG_WEIGHT_FAR]    = as_cfg(32767);
    cfg_plan[REG_ACCUM_MAX]     = as_cfg(DRIVE_MAX);
    cfg_plan[REG_ACCUM_MIN]     = as_cfg(DRIVE_MIN);
    program_regs();
    send_sample(0, 32767, -32768);
    send_sample(65535, 32767, -32768);
    send_sample(65535, 1, 0);
    send_sample(3277, -32768, 32767);
    send_sample(6554, 12345, -1);
    send_sample(0, -32768, 32767);
  endtask

  task automatic test_register_clamps();
    // Length below the minimum and an offset beyond the negative bound.
    wait_idle();
    cfg_plan[REG_BUFFER_LENGTH] = as_cfg(0);
    cfg_plan[REG_DELAY_COMP]    = as_cfg(-512);
    cfg_plan[REG_GAIN]          = as_cfg(16384);
    cfg_plan[REG_WEIGHT_CENTER] = as_cfg(8192);
    cfg_plan[REG_WEIGHT_NEAR]   = as_cfg(4096);
    cfg_plan[REG_WEIGHT_FAR]    = as_cfg(-4096);
    program_regs();
    send_sample(16'h8000, 20000, -3000);
    send_sample(16'h9000, -7, 900);
    send_sample(16'h7000, 32767, 0);
    send_sample(16'hFFFF, 0, 32767);
    // Length above the maximum and an offset beyond the positive bound.
    wait_idle();
    cfg_plan[REG_BUFFER_LENGTH] = as_cfg(511);
    cfg_plan[REG_DELAY_COMP]    = as_cfg(511);
    program_regs();
    send_sample(16'hF000, 5000, 100);
    send_sample(16'h0100, -5000, 100);
    send_sample(16'h0000, 222, -222);
    send_sample(16'hEA00, 17, 3);
    // Shorter length while the last slot still points past its end.
    wait_idle();
    cfg_plan[REG_BUFFER_LENGTH] = as_cfg(20);
    cfg_plan[REG_DELAY_COMP]    = as_cfg(-3);
    program_regs();
    send_sample(16'h1000, 1000, -1000);
    send_sample(16'h0000, -1000, 1000);
  endtask

  // When the lower limit is above the upper one, the lower one wins.
  task automatic test_crossed_limits();
    wait_idle();
    cfg_plan[REG_GAIN]      = as_cfg(32767);
    cfg_plan[REG_ACCUM_MAX] = as_cfg(-100);
    cfg_plan[REG_ACCUM_MIN] = as_cfg(100);
    program_regs();
    send_sample(16'h4000, -32768, 32767);
    send_sample(16'h4800, 32767, -32768);
    send_sample(16'h5000, 0, 0);
  endtask

  task automatic test_random_traffic(input int setting, input int n_items);
    int    len, slot_w, ph, stride, run_left, i, refv, fdbv, pick;
    walk_t walk;
    wait_idle();
    case (setting)
      0: cfg_plan[REG_BUFFER_LENGTH] = as_cfg(MIN_LEN);
      1: cfg_plan[REG_BUFFER_LENGTH] = as_cfg(MAX_LEN);
      2: cfg_plan[REG_BUFFER_LENGTH] = as_cfg($urandom_range(0, 511));
      default: cfg_plan[REG_BUFFER_LENGTH] = as_cfg($urandom_range(MIN_LEN, MAX_LEN));
    endcase
    len = effective_length(cfg_plan[REG_BUFFER_LENGTH][LEN_CFG_W-1:0]);
    case (setting)
      0: cfg_plan[REG_DELAY_COMP] = as_cfg(len);
      1: cfg_plan[REG_DELAY_COMP] = as_cfg(-len);
      2: cfg_plan[REG_DELAY_COMP] = as_cfg($urandom_range(0, 1023));
      default: cfg_plan[REG_DELAY_COMP] = as_cfg($urandom_range(0, 2 * len) - len);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      cfg_plan[REG_GAIN]          = as_cfg($urandom_range(0, 65535));
      cfg_plan[REG_WEIGHT_CENTER] = as_cfg($urandom_range(0, 65535));
      cfg_plan[REG_WEIGHT_NEAR]   = as_cfg($urandom_range(0, 65535));
      cfg_plan[REG_WEIGHT_FAR]    = as_cfg($urandom_range(0, 65535));
    end else begin
      // Narrower gain and weight ranges keep most of the history out of saturation.
      cfg_plan[REG_GAIN]          = as_cfg($urandom_range(0, 32767) - 16384);
      cfg_plan[REG_WEIGHT_CENTER] = as_cfg($urandom_range(8192, 16384));
      cfg_plan[REG_WEIGHT_NEAR]   = as_cfg($urandom_range(0, 8191) - 4096);
      cfg_plan[REG_WEIGHT_FAR]    = as_cfg($urandom_range(0, 4095) - 2048);
    end
    case ($urandom_range(0, 4))
      0: begin
        cfg_plan[REG_ACCUM_MAX] = as_cfg($urandom_range(0, 16777215));
        cfg_plan[REG_ACCUM_MIN] = as_cfg($urandom_range(0, 16777215));
      end
      1: begin
        cfg_plan[REG_ACCUM_MAX] = as_cfg($urandom_range(0, 2000000));
        cfg_plan[REG_ACCUM_MIN] = as_cfg(-$urandom_range(0, 2000000));
      end
      default: begin
        cfg_plan[REG_ACCUM_MAX] = as_cfg(DRIVE_MAX);
        cfg_plan[REG_ACCUM_MIN] = as_cfg(DRIVE_MIN);
      end
    endcase
    program_regs();

    slot_w = 65536 / len;
    ph = $urandom_range(0, 65535);
    run_left = 0;
    walk = SWEEP;
    stride = slot_w;
    for (i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        pick = $urandom_range(0, 9);
        walk = (pick < 6) ? SWEEP : (pick == 6) ? SCATTER : (pick < 9) ? DWELL : HALF_TURN;
        run_left = (walk == SWEEP) ? $urandom_range(8, 60) : $urandom_range(1, 5);
        stride = $urandom_range(slot_w / 3, 2 * slot_w);
        if ($urandom_range(0, 4) == 0) stride = -stride;
      end
      run_left--;
      case (walk)
        SWEEP:     ph = (ph + stride) & 16'hFFFF;
        SCATTER:   ph = $urandom_range(0, 65535);
        DWELL:     ph = (ph + $urandom_range(0, 2)) & 16'hFFFF;
        HALF_TURN: ph = (ph + 32768 + $urandom_range(0, 2 * slot_w) - slot_w) & 16'hFFFF;
        default:   ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        refv = $urandom_range(0, 65535);
        fdbv = $urandom_range(0, 65535);
      end else begin
        refv = $urandom_range(0, 8191) - 4096;
        fdbv = refv + $urandom_range(0, 1023) - 512;
      end
      if ($urandom_range(0, 149) == 0) wait_idle();
      send_sample(ph, refv, fdbv);
    end
  endtask

  initial begin : result_checker
    result_t want;
    stall_t  stall;
    int      tick;
    result_ready = 1'b0;
    stall = ALWAYS_READY;
    tick = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: drive %0d updated %0b",
                 $signed(result.drive), result.updated);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (result.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive),
                   $signed(result.drive));
            error_count++;
          end
          if (result.updated !== want.updated) begin
            $error("updated: expected %0b, got %0b", want.updated, result.updated);
            error_count++;
          end
        end
      end
      tick++;
      if (tick % 128 == 0) stall = stall_t'($urandom_range(0, 3));
      case (stall)
        ALWAYS_READY: result_ready <= 1'b1;
        COIN_FLIP:    result_ready <= $urandom_range(0, 1);
        SPARSE:       result_ready <= (tick % 8 == 0);
        default:      result_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_length   = BUFLEN_RST;
    cfg_delay    = DELAY_RST;
    cfg_gain     = GAIN_RST;
    cfg_w_center = WCENTER_RST;
    cfg_w_near   = WNEAR_RST;
    cfg_w_far    = WFAR_RST;
    cfg_acc_max  = AMAX_RST;
    cfg_acc_min  = AMIN_RST;
    for (n = 0; n < MAX_LEN; n++) error_history[n] = '0;
    prev_slot = 0;
    held_out = '0;
    cfg_plan[REG_BUFFER_LENGTH] = CFG_W'(BUFLEN_RST);
    cfg_plan[REG_DELAY_COMP]    = CFG_W'(DELAY_RST);
    cfg_plan[REG_GAIN]          = CFG_W'(GAIN_RST);
    cfg_plan[REG_WEIGHT_CENTER] = CFG_W'(WCENTER_RST);
    cfg_plan[REG_WEIGHT_NEAR]   = CFG_W'(WNEAR_RST);
    cfg_plan[REG_WEIGHT_FAR]    = CFG_W'(WFAR_RST);
    cfg_plan[REG_ACCUM_MAX]     = CFG_W'(AMAX_RST);
    cfg_plan[REG_ACCUM_MIN]     = CFG_W'(AMIN_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_field_extremes();
    test_register_clamps();
    test_crossed_limits();
    for (n = 0; n < 8; n++) test_random_traffic(n, 185);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/rc_pkg.sv
hdl/rc_mac.sv
hdl/rc_hist.sv
hdl/repetitive_controller.sv
hdl/rc_checker.sv
tb/tb.sv
